FILE: design/ccnt_pkg.sv
// shared constants, types and helpers of the coordination counter
package ccnt_pkg;

  // sizing
  localparam int MaxCols    = 4;
  localparam int PosBits    = 32;
  localparam int TypeBits   = 8;
  localparam int NumOutCols = 4;
  localparam int CountBits  = 16;
  localparam int BoundBits  = 8;
  localparam int CutBits    = 64;
  localparam int NcolBits   = 3;
  localparam int GroupBits  = 32;
  localparam int PackBits   = NumOutCols * BoundBits;
  localparam int SqBits     = 2 * PosBits;
  localparam int CmpBits    = (TypeBits > BoundBits) ? TypeBits : BoundBits;
  localparam int ColCap     = (MaxCols < NumOutCols) ? MaxCols : NumOutCols;
  localparam int CfgIdxBits = 3;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] CfgCutSq     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgNumCols   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgTypeLo    = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgTypeHi    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgCenterGrp = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgNbrGrp    = 3'd5;

  // item function codes
  localparam logic FuncStart    = 1'b0;
  localparam logic FuncNeighbor = 1'b1;

  typedef struct packed {
    logic [CutBits-1:0]   cut_sq;
    logic [NcolBits-1:0]  num_cols;
    logic [PackBits-1:0]  type_lo;
    logic [PackBits-1:0]  type_hi;
    logic [GroupBits-1:0] center_bits;
    logic [GroupBits-1:0] nbr_bits;
  } ccnt_cfg_t;

  // control that travels with an item through the back end
  typedef struct packed {
    logic                  is_start;
    logic                  sel;
    logic                  last;
    logic [NumOutCols-1:0] hit;
  } ccnt_ctl_t;

  // one classified item in the queue
  typedef struct packed {
    ccnt_ctl_t          ctl;
    logic [PosBits-1:0] dx;
    logic [PosBits-1:0] dy;
    logic [PosBits-1:0] dz;
  } ccnt_item_t;

  // one bit per column that is counted, out-of-range settings clamped
  function automatic logic [NumOutCols-1:0] act_mask(input logic [NcolBits-1:0] n);
    int                    n_eff;
    logic [NumOutCols-1:0] m;
    n_eff = int'(n);
    if (n_eff < 1) n_eff = 1;
    if (n_eff > ColCap) n_eff = ColCap;
    for (int i = 0; i < NumOutCols; i++) begin
      m[i] = (i < n_eff);
    end
    return m;
  endfunction

endpackage

FILE: design/ccnt_front.sv
// front end: takes items, tracks the center atom, classifies neighbors
module ccnt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccnt_pkg::ccnt_cfg_t          cfg_i,
  input  logic                         in_valid_i,
  input  logic                         q_full_i,
  input  logic                         func_i,
  input  logic signed [ccnt_pkg::PosBits-1:0] pos_x_i,
  input  logic signed [ccnt_pkg::PosBits-1:0] pos_y_i,
  input  logic signed [ccnt_pkg::PosBits-1:0] pos_z_i,
  input  logic [ccnt_pkg::GroupBits-1:0] group_mask_i,
  input  logic [ccnt_pkg::TypeBits-1:0]  atom_kind_i,
  input  logic                         last_i,
  output logic                         push_o,
  output ccnt_pkg::ccnt_item_t         item_o
);

  localparam int P = ccnt_pkg::PosBits;

  logic [P-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic         cgrp_q, cgrp_d;
  logic         start;
  logic         new_grp;
  logic         nbr_pass;
  logic [ccnt_pkg::NumOutCols-1:0] amask;
  logic [ccnt_pkg::NumOutCols-1:0] in_range;

  function automatic logic [P-1:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] d;
    logic [P:0] n;
    d = {a[P-1], a} - {b[P-1], b};
    n = -d;
    return d[P] ? n[P-1:0] : d[P-1:0];
  endfunction

  assign push_o  = in_valid_i && !q_full_i;
  assign start   = (func_i == ccnt_pkg::FuncStart);
  assign new_grp = |(group_mask_i & cfg_i.center_bits);
  assign amask   = ccnt_pkg::act_mask(cfg_i.num_cols);

  // group filter only applies with a single column
  assign nbr_pass = cgrp_q &&
                    !((amask == ccnt_pkg::NumOutCols'(1)) && !(|(group_mask_i & cfg_i.nbr_bits)));

  always_comb begin
    for (int m = 0; m < ccnt_pkg::NumOutCols; m++) begin
      in_range[m] =
        (ccnt_pkg::CmpBits'(atom_kind_i) >=
         ccnt_pkg::CmpBits'(cfg_i.type_lo[m*ccnt_pkg::BoundBits +: ccnt_pkg::BoundBits])) &&
        (ccnt_pkg::CmpBits'(atom_kind_i) <=
         ccnt_pkg::CmpBits'(cfg_i.type_hi[m*ccnt_pkg::BoundBits +: ccnt_pkg::BoundBits]));
    end
  end

  always_comb begin
    item_o.ctl.is_start = start;
    item_o.ctl.sel      = start ? new_grp : cgrp_q;
    item_o.ctl.last     = last_i;
    item_o.ctl.hit      = (!start && nbr_pass) ? (in_range & amask) : '0;
    item_o.dx           = abs_diff(pos_x_i, cx_q);
    item_o.dy           = abs_diff(pos_y_i, cy_q);
    item_o.dz           = abs_diff(pos_z_i, cz_q);
  end

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    cz_d   = cz_q;
    cgrp_d = cgrp_q;
    if (push_o && start) begin
      cx_d   = pos_x_i;
      cy_d   = pos_y_i;
      cz_d   = pos_z_i;
      cgrp_d = new_grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      cgrp_q <= 1'b0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      cgrp_q <= cgrp_d;
    end
  end

endmodule

FILE: design/ccnt_queue.sv
// short queue of classified items between front and back
module ccnt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ccnt_pkg::ccnt_item_t item_i,
  input  logic                 pop_i,
  output ccnt_pkg::ccnt_item_t item_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int Depth = 4;
  localparam int AW    = $clog2(Depth);

  ccnt_pkg::ccnt_item_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule

FILE: design/ccnt_back.sv
// back end: squares, saturating distance sum, cutoff test, counting, result register
module ccnt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccnt_pkg::ccnt_cfg_t  cfg_i,
  input  logic                 q_empty_i,
  input  ccnt_pkg::ccnt_item_t q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ccnt_pkg::CountBits-1:0] count_0_o,
  output logic [ccnt_pkg::CountBits-1:0] count_1_o,
  output logic [ccnt_pkg::CountBits-1:0] count_2_o,
  output logic [ccnt_pkg::CountBits-1:0] count_3_o,
  output logic                 center_selected_o
);

  localparam int N  = ccnt_pkg::NumOutCols;
  localparam int CB = ccnt_pkg::CountBits;
  localparam int SB = ccnt_pkg::CutBits;

  logic adv;

  // stage 1: squares
  logic                  v1_q;
  ccnt_pkg::ccnt_ctl_t   c1_q;
  logic [ccnt_pkg::SqBits-1:0] sqx_q, sqy_q, sqz_q, sqx_d, sqy_d, sqz_d;
  // stage 2: partial sum
  logic                  v2_q;
  ccnt_pkg::ccnt_ctl_t   c2_q;
  logic [SB-1:0]         sxy_q, sxy_d, sz_q;
  logic [SB:0]           sum_xy;
  // stage 3: cutoff test folded into the hit mask
  logic                  v3_q;
  ccnt_pkg::ccnt_ctl_t   c3_q, c3_d;
  logic [SB:0]           sum_all;
  logic [SB-1:0]         rsq;
  // counts and result
  logic [CB-1:0]         cnt_q [N];
  logic [CB-1:0]         cnt_d [N];
  logic [CB-1:0]         res_q [N];
  logic [CB-1:0]         res_d [N];
  logic                  out_valid_q, out_valid_d;
  logic                  osel_q;
  logic [N-1:0]          amask;

  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !q_empty_i;
  assign amask = ccnt_pkg::act_mask(cfg_i.num_cols);

  always_comb begin
    sqx_d = q_item_i.dx * q_item_i.dx;
    sqy_d = q_item_i.dy * q_item_i.dy;
    sqz_d = q_item_i.dz * q_item_i.dz;
  end

  assign sum_xy = {1'b0, SB'(sqx_q)} + {1'b0, SB'(sqy_q)};
  assign sxy_d  = sum_xy[SB] ? {SB{1'b1}} : sum_xy[SB-1:0];

  assign sum_all = {1'b0, sxy_q} + {1'b0, sz_q};
  assign rsq     = sum_all[SB] ? {SB{1'b1}} : sum_all[SB-1:0];

  always_comb begin
    c3_d     = c2_q;
    c3_d.hit = (rsq < cfg_i.cut_sq) ? c2_q.hit : '0;
  end

  always_comb begin
    for (int m = 0; m < N; m++) begin
      cnt_d[m] = cnt_q[m];
      res_d[m] = res_q[m];
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) begin
      out_valid_d = v3_q && c3_q.last;
      for (int m = 0; m < N; m++) begin
        if (v3_q) begin
          if (c3_q.is_start) begin
            cnt_d[m] = '0;
          end else if (c3_q.hit[m] && (cnt_q[m] != ccnt_pkg::CountMax)) begin
            cnt_d[m] = cnt_q[m] + CB'(1);
          end
        end
        res_d[m] = (c3_q.sel && amask[m]) ? cnt_d[m] : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q  <= q_item_i.ctl;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      c2_q  <= c1_q;
      sxy_q <= sxy_d;
      sz_q  <= SB'(sqz_q);
      c3_q  <= c3_d;
      osel_q <= c3_q.sel;
    end
    for (int m = 0; m < N; m++) begin
      res_q[m] <= res_d[m];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int m = 0; m < N; m++) begin
        cnt_q[m] <= '0;
      end
    end else begin
      if (adv) begin
        v1_q <= pop_o;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      out_valid_q <= out_valid_d;
      for (int m = 0; m < N; m++) begin
        cnt_q[m] <= cnt_d[m];
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign count_0_o         = res_q[0];
  assign count_1_o         = res_q[1];
  assign count_2_o         = res_q[2];
  assign count_3_o         = res_q[3];
  assign center_selected_o = osel_q;

  a_unsel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !center_selected_o) |->
      (count_0_o == '0 && count_1_o == '0 && count_2_o == '0 && count_3_o == '0))
    else $error("unselected center reported nonzero counts");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !amask[N-1]) |-> (count_3_o == '0))
    else $error("inactive column reported nonzero count");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v3_q && c3_q.is_start) |=> (cnt_q[0] == '0))
    else $error("start item did not clear counts");

endmodule

FILE: design/coordination_count.sv
// top level of the coordination counter: config registers, front, queue, back
//
//  channel   direction  handshake            payload
//  in        sink       in_valid_i/in_stall_o  func, pos_x/y/z, group_mask, atom_kind, last
//  out       source     out_valid_o/out_stall_i count_0..3, center_selected
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle sustained while in_stall_o is low; the front classifies in the accept
// cycle, and a result passes the queue and three back stages (squares, partial sum, cutoff
// test), then leaves from the count/result register
// reset clears config to defaults (num_cols = 1), the center and all counts
// the back end freezes only while a result waits under out_stall_i; the
// four-entry queue keeps taking items until it fills, then in_stall_o rises
// cfg_ready_o is always high; writes take effect on the next cycle
module coordination_count (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input transaction
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic signed [ccnt_pkg::PosBits-1:0]  pos_x_i,
  input  logic signed [ccnt_pkg::PosBits-1:0]  pos_y_i,
  input  logic signed [ccnt_pkg::PosBits-1:0]  pos_z_i,
  input  logic [ccnt_pkg::GroupBits-1:0]       group_mask_i,
  input  logic [ccnt_pkg::TypeBits-1:0]        atom_kind_i,
  input  logic                                 last_i,
  // result transaction
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ccnt_pkg::CountBits-1:0]       count_0_o,
  output logic [ccnt_pkg::CountBits-1:0]       count_1_o,
  output logic [ccnt_pkg::CountBits-1:0]       count_2_o,
  output logic [ccnt_pkg::CountBits-1:0]       count_3_o,
  output logic                                 center_selected_o,
  // configuration write transaction
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ccnt_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [ccnt_pkg::CutBits-1:0]         cfg_data_i
);

  ccnt_pkg::ccnt_cfg_t  cfg_q, cfg_d;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  ccnt_pkg::ccnt_item_t push_item;
  ccnt_pkg::ccnt_item_t pop_item;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // register file write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ccnt_pkg::CfgCutSq:     cfg_d.cut_sq      = cfg_data_i;
        ccnt_pkg::CfgNumCols:   cfg_d.num_cols    = cfg_data_i[ccnt_pkg::NcolBits-1:0];
        ccnt_pkg::CfgTypeLo:    cfg_d.type_lo     = cfg_data_i[ccnt_pkg::PackBits-1:0];
        ccnt_pkg::CfgTypeHi:    cfg_d.type_hi     = cfg_data_i[ccnt_pkg::PackBits-1:0];
        ccnt_pkg::CfgCenterGrp: cfg_d.center_bits = cfg_data_i[ccnt_pkg::GroupBits-1:0];
        ccnt_pkg::CfgNbrGrp:    cfg_d.nbr_bits    = cfg_data_i[ccnt_pkg::GroupBits-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cut_sq:      '0,
                 num_cols:    ccnt_pkg::NcolBits'(1),
                 type_lo:     '0,
                 type_hi:     '0,
                 center_bits: '0,
                 nbr_bits:    '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: center tracking, distance deltas, type and group classification
  ccnt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .q_full_i     (q_full),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .group_mask_i (group_mask_i),
    .atom_kind_i  (atom_kind_i),
    .last_i       (last_i),
    .push_o       (push),
    .item_o       (push_item)
  );

  // decouples accept from result back-pressure
  ccnt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: squared distance, cutoff compare, saturating counts, result register
  ccnt_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (q_empty),
    .q_item_i          (pop_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .count_0_o         (count_0_o),
    .count_1_o         (count_1_o),
    .count_2_o         (count_2_o),
    .count_3_o         (count_3_o),
    .center_selected_o (center_selected_o)
  );

endmodule

FILE: dv/coordination_count_checker.sv
// checker of the coordination counter: predicts the counts of each center atom and compares results
module coordination_count_checker
  import ccnt_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       func_i,
  input  logic signed [PosBits-1:0]  pos_x_i,
  input  logic signed [PosBits-1:0]  pos_y_i,
  input  logic signed [PosBits-1:0]  pos_z_i,
  input  logic [GroupBits-1:0]       group_mask_i,
  input  logic [TypeBits-1:0]        atom_kind_i,
  input  logic                       last_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [CountBits-1:0]       count_0_i,
  input  logic [CountBits-1:0]       count_1_i,
  input  logic [CountBits-1:0]       count_2_i,
  input  logic [CountBits-1:0]       count_3_i,
  input  logic                       center_selected_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CfgIdxBits-1:0]      cfg_index_i,
  input  logic [CutBits-1:0]         cfg_data_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NumOutCols-1:0][CountBits-1:0] cnt;
    logic                                 sel;
  } tally_t;

  tally_t counts_due_q[$];

  // register copies
  logic [CutBits-1:0]   cut_sq_q;
  logic [NcolBits-1:0]  ncols_q;
  logic [PackBits-1:0]  type_lo_q;
  logic [PackBits-1:0]  type_hi_q;
  logic [GroupBits-1:0] center_grp_q;
  logic [GroupBits-1:0] nbr_grp_q;

  // center atom and its running counts
  logic signed [PosBits-1:0]            ctr_x, ctr_y, ctr_z;
  logic                                 ctr_sel;
  logic [NumOutCols-1:0][CountBits-1:0] tally;
  int                                   fails = 0;

  // exact square of one coordinate difference
  function automatic logic [SqBits-1:0] axis_sq(input logic signed [PosBits-1:0] a,
                                                input logic signed [PosBits-1:0] b);
    logic signed [PosBits:0] d;
    logic [PosBits:0]        mag;
    logic [SqBits-1:0]       w;
    d   = {a[PosBits-1], a} - {b[PosBits-1], b};
    mag = d[PosBits] ? -d : d;
    w   = mag[PosBits-1:0];
    return w * w;
  endfunction

  // sum of the three squares, pinned at all ones
  function automatic logic [SqBits-1:0] dist_sq(input logic signed [PosBits-1:0] x,
                                                input logic signed [PosBits-1:0] y,
                                                input logic signed [PosBits-1:0] z);
    logic [SqBits+1:0] acc;
    acc = {2'b00, axis_sq(x, ctr_x)} + {2'b00, axis_sq(y, ctr_y)} + {2'b00, axis_sq(z, ctr_z)};
    if (acc[SqBits+1:SqBits] != 2'b00) return '1;
    return acc[SqBits-1:0];
  endfunction

  function automatic int cols_in_use(input logic [NcolBits-1:0] n);
    int k;
    k = int'(n);
    if (k < 1) k = 1;
    if (k > ColCap) k = ColCap;
    return k;
  endfunction

  task automatic write_reg();
    case (cfg_index_i)
      CfgCutSq:     cut_sq_q = cfg_data_i;
      CfgNumCols:   ncols_q = cfg_data_i[NcolBits-1:0];
      CfgTypeLo:    type_lo_q = cfg_data_i[PackBits-1:0];
      CfgTypeHi:    type_hi_q = cfg_data_i[PackBits-1:0];
      CfgCenterGrp: center_grp_q = cfg_data_i[GroupBits-1:0];
      CfgNbrGrp:    nbr_grp_q = cfg_data_i[GroupBits-1:0];
      default: ;
    endcase
  endtask

  task automatic count_neighbors();
    int                   ncols;
    int                   m;
    logic [BoundBits-1:0] lo, hi;
    tally_t               res;
    ncols = cols_in_use(ncols_q);
    if (func_i == FuncStart) begin
      ctr_x   = pos_x_i;
      ctr_y   = pos_y_i;
      ctr_z   = pos_z_i;
      ctr_sel = (group_mask_i & center_grp_q) != '0;
      tally   = '0;
    end else if (ctr_sel && !(ncols == 1 && (group_mask_i & nbr_grp_q) == '0)) begin
      if (dist_sq(pos_x_i, pos_y_i, pos_z_i) < cut_sq_q) begin
        for (m = 0; m < ncols; m++) begin
          lo = type_lo_q[m*BoundBits +: BoundBits];
          hi = type_hi_q[m*BoundBits +: BoundBits];
          if (atom_kind_i >= lo && atom_kind_i <= hi && tally[m] != CountMax)
            tally[m] = tally[m] + 1'b1;
        end
      end
    end
    if (last_i) begin
      res = '0;
      for (m = 0; m < NumOutCols; m++) begin
        if (ctr_sel && m < ncols) res.cnt[m] = tally[m];
      end
      res.sel = ctr_sel;
      counts_due_q.push_back(res);
    end
  endtask

  task automatic check_counts();
    tally_t                               want;
    logic [NumOutCols-1:0][CountBits-1:0] got;
    int                                   m;
    got = {count_3_i, count_2_i, count_1_i, count_0_i};
    if (counts_due_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected result, expected none, actual counts %h selected %b",
               $time, got, center_selected_i);
    end else begin
      want = counts_due_q.pop_front();
      for (m = 0; m < NumOutCols; m++) begin
        if (got[m] !== want.cnt[m]) begin
          fails++;
          $display("%0t: count_%0d expected %0d actual %0d", $time, m, want.cnt[m], got[m]);
        end
      end
      if (center_selected_i !== want.sel) begin
        fails++;
        $display("%0t: center_selected expected %b actual %b", $time, want.sel,
                 center_selected_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_sq_q     = '0;
      ncols_q      = NcolBits'(1);
      type_lo_q    = '0;
      type_hi_q    = '0;
      center_grp_q = '0;
      nbr_grp_q    = '0;
      ctr_x        = '0;
      ctr_y        = '0;
      ctr_z        = '0;
      ctr_sel      = 1'b0;
      tally        = '0;
      counts_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg();
      if (in_valid_i && !in_stall_i) count_neighbors();
      if (out_valid_i && !out_stall_i) check_counts();
    end
    pending_o    <= counts_due_q.size();
    fail_count_o <= fails;
  end

endmodule

FILE: dv/coordination_count_tb.sv
// testbench top of the coordination counter: stimulus, idling on both channels and the verdict
module coordination_count_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccnt_pkg::*;

  localparam logic signed [PosBits-1:0] PosMin = {1'b1, {(PosBits-1){1'b0}}};
  localparam logic signed [PosBits-1:0] PosMax = {1'b0, {(PosBits-1){1'b1}}};
  // an index with no register behind it, writes there must be ignored
  localparam logic [CfgIdxBits-1:0]     CfgSpare = 3'd7;
  localparam int RandItems    = 400;
  localparam int PhaseItems   = 40;
  // pipeline depth plus queue depth, with margin
  localparam int DrainCycles  = 12;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   func_i = FuncStart;
  logic signed [PosBits-1:0] pos_x_i = '0;
  logic signed [PosBits-1:0] pos_y_i = '0;
  logic signed [PosBits-1:0] pos_z_i = '0;
  logic [GroupBits-1:0]   group_mask_i = '0;
  logic [TypeBits-1:0]    atom_kind_i = '0;
  logic                   last_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [CountBits-1:0]   count_0_o, count_1_o, count_2_o, count_3_o;
  logic                   center_selected_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CutBits-1:0]     cfg_data_i = '0;

  int pending;
  int fails;

  // no idling on either side while set
  bit                   steady = 1'b0;
  // group bits in force, used to steer masks in or out of the groups
  logic [GroupBits-1:0] cur_cgrp = '0;
  logic [GroupBits-1:0] cur_ngrp = '0;
  int                   stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coordination_count dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .func_i, .pos_x_i, .pos_y_i, .pos_z_i, .group_mask_i, .atom_kind_i, .last_i,
    .out_valid_o, .out_stall_i,
    .count_0_o, .count_1_o, .count_2_o, .count_3_o, .center_selected_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  coordination_count_checker watch (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o),
    .func_i, .pos_x_i, .pos_y_i, .pos_z_i, .group_mask_i, .atom_kind_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .count_0_i(count_0_o), .count_1_i(count_1_o), .count_2_i(count_2_o),
    .count_3_i(count_3_o), .center_selected_i(center_selected_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fails)
  );

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // random mask pushed into or out of a group
  function automatic logic [GroupBits-1:0] member_mask(input logic [GroupBits-1:0] grp,
                                                       input bit member);
    logic [GroupBits-1:0] m;
    m = $urandom;
    if (member) m = m | (grp & (~grp + 1'b1));
    else m = m & ~grp;
    return m;
  endfunction

  function automatic logic [GroupBits-1:0] pick_group();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // signed offset within +/- 2^s
  function automatic logic signed [PosBits-1:0] near(input int s);
    int off;
    off = $urandom_range(0, 2 << s);
    return off - (1 << s);
  endfunction

  // result side: after each result transaction, hold stall for a drawn number of cycles
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = draw_wait();
      if (stall_left > 0) out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall_i <= 1'b0;
    end
  end

  // one item transaction; valid stays high when the next item follows without a gap
  task automatic send_item(input logic f, input logic signed [PosBits-1:0] x,
                           input logic signed [PosBits-1:0] y,
                           input logic signed [PosBits-1:0] z,
                           input logic [GroupBits-1:0] mask,
                           input logic [TypeBits-1:0] kind, input logic lst);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    pos_x_i      <= x;
    pos_y_i      <= y;
    pos_z_i      <= z;
    group_mask_i <= mask;
    atom_kind_i  <= kind;
    last_i       <= lst;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // config transaction; valid is lowered by the caller once the series is done
  task automatic put_reg(input logic [CfgIdxBits-1:0] idx, input logic [CutBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_cfg(input logic [CutBits-1:0] cut, input logic [NcolBits-1:0] ncols,
                          input logic [PackBits-1:0] lo, input logic [PackBits-1:0] hi,
                          input logic [GroupBits-1:0] cgrp,
                          input logic [GroupBits-1:0] ngrp);
    put_reg(CfgCutSq, cut);
    put_reg(CfgNumCols, CutBits'(ncols));
    put_reg(CfgTypeLo, CutBits'(lo));
    put_reg(CfgTypeHi, CutBits'(hi));
    put_reg(CfgCenterGrp, CutBits'(cgrp));
    put_reg(CfgNbrGrp, CutBits'(ngrp));
    cfg_valid_i <= 1'b0;
    cur_cgrp = cgrp;
    cur_ngrp = ngrp;
  endtask

  // wait until every expected result is in, then let items without a result flush
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_setting(input int ph);
    logic [CutBits-1:0]   cut, r;
    logic [PackBits-1:0]  lo, hi;
    logic [BoundBits-1:0] a, b;
    int                   m;
    case ($urandom_range(0, 5))
      0: cut = '0;
      1: cut = '1;
      default: begin
        r   = CutBits'($urandom_range(1, 1 << 18));
        cut = r * r;
      end
    endcase
    for (m = 0; m < NumOutCols; m++) begin
      a = BoundBits'($urandom_range(0, 255));
      b = BoundBits'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        // full type range
        0: begin
          lo[m*BoundBits +: BoundBits] = '0;
          hi[m*BoundBits +: BoundBits] = '1;
        end
        1: begin
          lo[m*BoundBits +: BoundBits] = (a < b) ? a : b;
          hi[m*BoundBits +: BoundBits] = (a < b) ? b : a;
        end
        // inverted bounds, an empty column unless both draws are equal
        2: begin
          lo[m*BoundBits +: BoundBits] = (a < b) ? b : a;
          hi[m*BoundBits +: BoundBits] = (a < b) ? a : b;
        end
        default: begin
          lo[m*BoundBits +: BoundBits] = a;
          hi[m*BoundBits +: BoundBits] = a;
        end
      endcase
    end
    // walk num_cols through every encoding, zero and above four included
    load_cfg(cut, NcolBits'(ph % 8), lo, hi, pick_group(), pick_group());
    steady = (ph % 3 == 2);
  endtask

  // mostly whole atoms with neighbors around the center, the rest loose items
  task automatic random_phase();
    int                        left, n_nbr, s, k;
    logic signed [PosBits-1:0] cx, cy, cz;
    left = PhaseItems;
    while (left > 0) begin
      if ($urandom_range(0, 4) != 0) begin
        cx    = $urandom;
        cy    = $urandom;
        cz    = $urandom;
        n_nbr = $urandom_range(0, 8);
        s     = $urandom_range(4, 19);
        send_item(FuncStart, cx, cy, cz, member_mask(cur_cgrp, $urandom_range(0, 6) != 0),
                  TypeBits'($urandom_range(0, 255)), n_nbr == 0);
        for (k = 1; k <= n_nbr; k++) begin
          send_item(FuncNeighbor, cx + near(s), cy + near(s), cz + near(s),
                    member_mask(cur_ngrp, $urandom_range(0, 3) != 0),
                    TypeBits'($urandom_range(0, 255)), k == n_nbr);
        end
        left -= n_nbr + 1;
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                  TypeBits'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a neighbor before any start sees the unselected reset center,
    // and with no center group bits no start is selected either
    send_item(FuncNeighbor, PosMax, PosMax, PosMax, '1, 8'hFF, 1'b1);
    send_item(FuncStart, '0, '0, '0, '1, 8'h00, 1'b1);
    drain();

    // four columns, widest cutoff; columns 0:[00,ff] 1:[80,ff] 2:[00,7f] 3:[c0,ff]
    put_reg(CfgSpare, '1);
    load_cfg('1, NcolBits'(4), 32'hC000_8000, 32'hFF7F_FFFF, 32'h8000_0001,
             32'h0000_0100);
    send_item(FuncStart, PosMin, PosMin, PosMin, 32'h8000_0000, 8'h00, 1'b0);
    // opposite corner: the squared distance saturates and is not below the cutoff
    send_item(FuncNeighbor, PosMax, PosMax, PosMax, '0, 8'hFF, 1'b0);
    send_item(FuncNeighbor, PosMin, PosMin, PosMin, '0, 8'h00, 1'b0);
    send_item(FuncNeighbor, PosMin + 1, PosMin, PosMin, '0, 8'h80, 1'b0);
    send_item(FuncNeighbor, PosMin, PosMin, PosMin + 1, '1, 8'hC0, 1'b1);
    // neighbor after last without a new start keeps counting the same center
    send_item(FuncNeighbor, PosMin, PosMin, PosMin, '0, 8'h7F, 1'b1);
    // start marked last gives cleared counts at once
    send_item(FuncStart, PosMax, PosMin, '0, 32'h0000_0001, 8'hFF, 1'b1);
    // center outside the group: neighbors change nothing
    send_item(FuncStart, '0, '0, '0, 32'h7FFF_FFFE, 8'h00, 1'b0);
    send_item(FuncNeighbor, '0, '0, '0, '1, 8'h00, 1'b1);
    drain();

    // one column: neighbor group filter and the strict cutoff at 16.0
    load_cfg(64'd1 << 40, NcolBits'(1), '0, 32'h0000_00FF, '1, 32'h0000_0100);
    send_item(FuncStart, 32'sd12345, -32'sd6789, '0, 32'h0000_0001, 8'h00, 1'b0);
    send_item(FuncNeighbor, 32'sd12345, -32'sd6789, '0, 32'hFFFF_FEFF, 8'h10, 1'b0);
    send_item(FuncNeighbor, 32'sd12345 + (1 << 20), -32'sd6789, '0, 32'h0000_0100,
              8'h10, 1'b0);
    send_item(FuncNeighbor, 32'sd12345 + (1 << 20) - 1, -32'sd6789, '0, 32'h0000_0100,
              8'h10, 1'b1);
    drain();

    // column count above four clamps; zero cutoff counts nothing
    load_cfg('0, NcolBits'(7), '0, '1, '1, '0);
    send_item(FuncStart, '0, '0, '0, 32'h0000_0001, 8'h00, 1'b0);
    send_item(FuncNeighbor, '0, '0, '0, '1, 8'h00, 1'b1);

    // random settings, each followed by a burst of atoms
    for (int ph = 0; ph < RandItems / PhaseItems; ph++) begin
      drain();
      random_setting(ph);
      random_phase();
    end

    drain();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
